// ----- rtl/sst_pkg.sv -----
package sst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int OUTC_W   = 2;
    localparam int ELEM_W   = 7;
    localparam int S_DATA_W = ((FUNC_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OUTC_W + ELEM_W + 1 + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [OUTC_W-1:0] OUTC_DONE = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_MISS = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_FULL = 2'd2;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

    function automatic logic [ELEM_W-1:0] fmt_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+ELEM_W-1:0] w;
        w = {{ELEM_W{1'b0}}, c};
        return w[ELEM_W-1:0];
    endfunction

endpackage

// ----- rtl/sst_ram.sv -----
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sst_cmp.sv -----
module sst_cmp (
    input  logic signed [sst_pkg::VALUE_W-1:0] entry,
    input  logic signed [sst_pkg::VALUE_W-1:0] key,
    output sst_pkg::cmp_res_t                  res
);
    import sst_pkg::*;

    always_comb
    begin
        res.eq = (entry == key);
        res.gt = (entry > key);
    end

endmodule

// ----- rtl/sorted_set_table.sv -----
// Ordered set of up to CAPACITY distinct signed 32-bit values.
// Each input item on the s_ channel carries an operation (insert, remove or
// membership query) and a value. Each item yields exactly one item on the
// m_ channel with an outcome code, the element count after the operation
// and an empty flag.
// The block takes one item at a time: s_tready is high only while it is
// idle. A query costs the scan up to the first entry not below the value.
// An insert or remove adds a shift of the entries above the position, one
// entry per cycle. The single read port of the entry memory serves both
// the scan and the shift.
// Reset empties the set at once; the memory is not cleared, since entries
// at or beyond the count are never used.
// The result is held on m_tdata with m_tvalid high until m_tready accepts
// it; a stalled receiver holds the block, and no new item is taken until
// the result leaves.
module sorted_set_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func [1:0], value [33:2], zero fill above
    input  logic [sst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // outcome [1:0], element_count [8:2], is_empty [9], zero fill above
    output logic [sst_pkg::M_DATA_W-1:0]  m_tdata
);
    import sst_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SHUP   = 3'd3;
    localparam logic [2:0] ST_SHDN   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]          state_reg,    state_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic [CNT_W-1:0]    src_reg,      src_next;
    logic [CNT_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                pend_reg,     pend_next;
    logic [CNT_W-1:0]    pos_reg,      pos_next;
    logic                hit_reg,      hit_next;
    logic [FUNC_W-1:0]   func_reg,     func_next;
    logic [VALUE_W-1:0]  key_reg,      key_next;
    logic [OUTC_W-1:0]   outcome_reg,  outcome_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [CNT_W-1:0]    raddr_full;
    logic [VALUE_W-1:0]  ram_rdata;
    cmp_res_t            cmp;
    logic [CNT_W-1:0]    src_dec;
    logic [CNT_W-1:0]    src_inc;

    sst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sst_cmp u_cmp (
        .entry (ram_rdata),
        .key   (key_reg),
        .res   (cmp)
    );

    assign src_dec   = src_reg - CNT_W'(1);
    assign src_inc   = src_reg + CNT_W'(1);
    assign ram_raddr = raddr_full[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        src_next      = src_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = pend_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        outcome_next  = outcome_reg;
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg[IDX_W-1:0];
        ram_wdata     = ram_rdata;
        raddr_full    = src_reg;

        case (state_reg)
            ST_IDLE:
            begin
                pend_next = 1'b0;
                if (s_tvalid)
                begin
                    func_next  = s_tdata[FUNC_W-1:0];
                    key_next   = s_tdata[FUNC_W+VALUE_W-1:FUNC_W];
                    src_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (cmp.eq || cmp.gt))
                begin
                    pos_next   = pend_idx_reg;
                    hit_next   = cmp.eq;
                    pend_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
                else if (src_reg == count_reg)
                begin
                    pos_next   = count_reg;
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = src_reg;
                    src_next      = src_inc;
                end
            end
            ST_DECIDE:
            begin
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            outcome_next = OUTC_MISS;
                            state_next   = ST_OUT;
                        end
                        else if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            outcome_next = OUTC_FULL;
                            state_next   = ST_OUT;
                        end
                        else
                        begin
                            outcome_next = OUTC_DONE;
                            src_next     = count_reg;
                            state_next   = ST_SHUP;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            outcome_next = OUTC_DONE;
                            src_next     = pos_reg + CNT_W'(1);
                            state_next   = ST_SHDN;
                        end
                        else
                        begin
                            outcome_next = OUTC_MISS;
                            state_next   = ST_OUT;
                        end
                    end
                    default:
                    begin
                        outcome_next = hit_reg ? OUTC_DONE : OUTC_MISS;
                        state_next   = ST_OUT;
                    end
                endcase
            end
            ST_SHUP:
            begin
                raddr_full = src_dec;
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (src_reg != pos_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = src_reg;
                    src_next      = src_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = pos_reg[IDX_W-1:0];
                        ram_wdata  = key_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SHDN:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (src_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = src_dec;
                    src_next      = src_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        outcome_reg  <= outcome_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = M_DATA_W'({(count_reg == '0), fmt_count(count_reg), outcome_reg});

endmodule

// ----- test/tb_sorted_set_table.sv -----
module tb_sorted_set_table;
    import sst_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [ELEM_W-1:0] count;
        logic              empty;
    } set_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [S_DATA_W-1:0] request_queue[$];
    set_reply_t          awaited_replies[$];
    int                  set_members[$];
    int                  known_values[$];

    int items_queued = 0;
    int items_accepted = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic calm = 1'b0;
    logic hold_off = 1'b0;
    set_reply_t want;

    sorted_set_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Applies one request to the shadow set and returns the reply it causes.
    function automatic set_reply_t apply_request(input logic [FUNC_W-1:0] op, input int key);
        set_reply_t r;
        int pos;
        bit hit;
        pos = 0;
        while (pos < set_members.size() && set_members[pos] < key)
            pos++;
        hit = (pos < set_members.size()) && (set_members[pos] == key);
        r.outcome = OUTC_MISS;
        if (op == FUNC_INSERT)
        begin
            if (hit)
                r.outcome = OUTC_MISS;
            else if (set_members.size() >= CAPACITY)
                r.outcome = OUTC_FULL;
            else
            begin
                set_members.insert(pos, key);
                r.outcome = OUTC_DONE;
            end
        end
        else if (op == FUNC_REMOVE)
        begin
            if (hit)
            begin
                set_members.delete(pos);
                r.outcome = OUTC_DONE;
            end
        end
        else
            r.outcome = hit ? OUTC_DONE : OUTC_MISS;
        r.count = ELEM_W'(set_members.size());
        r.empty = (set_members.size() == 0);
        return r;
    endfunction

    function automatic void add_request(input logic [FUNC_W-1:0] op, input int key);
        bit seen;
        request_queue.push_back({{(S_DATA_W - FUNC_W - VALUE_W){1'b0}}, key, op});
        items_queued++;
        if (op == FUNC_INSERT)
        begin
            seen = 0;
            foreach (known_values[i])
                if (known_values[i] == key)
                    seen = 1;
            if (!seen)
                known_values.push_back(key);
        end
    endfunction

    function automatic int pick_known();
        if (known_values.size() == 0)
            return $urandom();
        return known_values[$urandom_range(0, known_values.size() - 1)];
    endfunction

    initial
    begin
        int kind;
        int idx;
        int key;
        int r;
        logic [FUNC_W-1:0] op;

        // Directed part: empty set, extremes, duplicates, unused selector.
        add_request(FUNC_QUERY, 0);
        add_request(FUNC_REMOVE, 32'h8000_0000);
        add_request(FUNC_INSERT, 32'h8000_0000);
        add_request(FUNC_INSERT, 32'h7FFF_FFFF);
        add_request(FUNC_INSERT, 0);
        add_request(FUNC_INSERT, -1);
        add_request(FUNC_INSERT, 1);
        add_request(FUNC_INSERT, 32'h7FFF_FFFF);
        add_request(FUNC_QUERY, 32'h8000_0000);
        add_request(FUNC_QUERY, 32'h7FFF_FFFF);
        add_request(FUNC_QUERY, 5);
        add_request(FUNC_UNUSED, 0);
        add_request(FUNC_UNUSED, 7);
        add_request(FUNC_REMOVE, 32'h7FFF_FFFF);
        add_request(FUNC_REMOVE, 32'h7FFF_FFFF);
        add_request(FUNC_REMOVE, 32'h8000_0000);
        add_request(FUNC_INSERT, 32'h5555_5555);
        add_request(FUNC_INSERT, 32'hAAAA_AAAA);
        add_request(FUNC_QUERY, 32'hAAAA_AAAA);
        add_request(FUNC_REMOVE, 0);
        add_request(FUNC_REMOVE, -1);
        add_request(FUNC_REMOVE, 1);
        add_request(FUNC_REMOVE, 32'h5555_5555);
        add_request(FUNC_REMOVE, 32'hAAAA_AAAA);
        add_request(FUNC_QUERY, 32'hAAAA_AAAA);
        known_values.delete();

        while (items_queued < RANDOM_ITEMS + 25)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                // Mixed traffic on a small set of values so hits are common.
                repeat (30)
                begin
                    r = $urandom_range(0, 19);
                    op = (r < 8) ? FUNC_INSERT : (r < 14) ? FUNC_REMOVE :
                         (r < 19) ? FUNC_QUERY : FUNC_UNUSED;
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        key = pick_known();
                    else if (r < 8)
                    begin
                        case ($urandom_range(0, 4))
                            0: key = 32'h8000_0000;
                            1: key = 32'h7FFF_FFFF;
                            2: key = 0;
                            3: key = -1;
                            default: key = 1;
                        endcase
                    end
                    else
                        key = $urandom();
                    add_request(op, key);
                end
            end
            else if (kind < 6)
            begin
                // Fill past capacity, then probe the full store.
                repeat (72)
                    add_request(FUNC_INSERT, $urandom());
                repeat (3)
                    add_request(FUNC_INSERT, pick_known());
                repeat (3)
                    add_request(FUNC_QUERY, pick_known());
                add_request(FUNC_REMOVE, pick_known());
                add_request(FUNC_INSERT, $urandom());
            end
            else if (kind < 8)
            begin
                // Drain every value ever inserted, in random order.
                while (known_values.size() > 0)
                begin
                    idx = $urandom_range(0, known_values.size() - 1);
                    key = known_values[idx];
                    known_values.delete(idx);
                    add_request(FUNC_REMOVE, key);
                    if ($urandom_range(0, 7) == 0)
                        add_request(FUNC_QUERY, pick_known());
                end
                add_request(FUNC_REMOVE, $urandom());
                add_request(FUNC_QUERY, $urandom());
            end
            else
            begin
                repeat (20)
                    add_request(FUNC_W'($urandom_range(0, 3)), $urandom());
            end
        end

        wait (items_accepted == items_queued);
        wait (replies_seen == items_accepted);
        repeat (100) @(posedge clk);
        if (awaited_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // The receiver holds off for a long stretch while requests keep coming.
    initial
    begin
        wait (items_accepted >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (500) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 3000 == 2999)
            calm <= ~calm;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_replies.push_back(
                    apply_request(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: VALUE_W]));
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    s_tdata <= request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (awaited_replies.size() == 0)
                    report_mismatch($sformatf("unexpected reply %h", m_tdata));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_tdata[1:0] !== want.outcome)
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  m_tdata[1:0], want.outcome));
                    if (m_tdata[8:2] !== want.count)
                        report_mismatch($sformatf("element_count %0d, expected %0d",
                                                  m_tdata[8:2], want.count));
                    if (m_tdata[9] !== want.empty)
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  m_tdata[9], want.empty));
                    if (m_tdata[M_DATA_W-1:10] !== '0)
                        report_mismatch($sformatf("fill bits not zero in %h", m_tdata));
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                recv_gap = pick_gap();
                m_tready <= (recv_gap == 0);
            end
        end
    end

endmodule
